// ===== hw/rtl/apf_pkg.sv =====
`timescale 1ns / 1ps
package apf_pkg;

  // Fixed field widths
  localparam int VTX_W  = 6;
  localparam int CFG_W  = 7;
  localparam int DISC_W = 7;
  localparam int ACT_W  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_INIT,
    S_ROOT,
    S_DISC_A,
    S_DISC_B,
    S_EDGE_A,
    S_EDGE_B,
    S_EDGE_C,
    S_POP_A,
    S_POP_B,
    S_OUT_A,
    S_OUT_B,
    S_OUT_C
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_rd;
    logic drop;
    logic load_wr;
    logic clear;
    logic run_init;
    logic root_next;
    logic root_start;
    logic head_rd;
    logic disc_do;
    logic edge_rd;
    logic edge_chk;
    logic disc_cmp;
    logic pop_a;
    logic pop_b;
    logic out_rd;
    logic out_load;
    logic out_adv;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_ok;
    logic full;
    logic r_done;
    logic r_seen;
    logic e_end;
    logic t_oob;
    logic t_seen;
    logic sp_one;
    logic can_push;
    logic out_last;
  } status_t;

endpackage

// ===== hw/rtl/apf_ram.sv =====
`timescale 1ns / 1ps
module apf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/apf_ctrl.sv =====
`timescale 1ns / 1ps
module apf_ctrl import apf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic [ACT_W-1:0] action,
  input  logic             m_tready,
  input  status_t          sts,
  output logic             s_tready,
  output cmd_t             cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_LOAD && sts.in_ok && !sts.full) begin
            state_next = S_LOAD;
          end else if (action == ACT_RUN) begin
            state_next = S_INIT;
          end
        end
      end
      S_LOAD:   state_next = S_IDLE;
      S_INIT:   state_next = S_ROOT;
      S_ROOT: begin
        if (sts.r_done) begin
          state_next = S_OUT_A;
        end else if (!sts.r_seen) begin
          state_next = S_DISC_A;
        end
      end
      S_DISC_A: state_next = S_DISC_B;
      S_DISC_B: state_next = S_EDGE_A;
      S_EDGE_A: state_next = sts.e_end ? S_POP_A : S_EDGE_B;
      S_EDGE_B: begin
        if (sts.t_oob) begin
          state_next = S_EDGE_A;
        end else if (!sts.t_seen) begin
          state_next = sts.can_push ? S_DISC_A : S_EDGE_A;
        end else begin
          state_next = S_EDGE_C;
        end
      end
      S_EDGE_C: state_next = S_EDGE_A;
      S_POP_A:  state_next = sts.sp_one ? S_ROOT : S_POP_B;
      S_POP_B:  state_next = S_EDGE_A;
      S_OUT_A:  state_next = S_OUT_B;
      S_OUT_B:  state_next = S_OUT_C;
      S_OUT_C: begin
        if (m_tready) begin
          state_next = sts.out_last ? S_IDLE : S_OUT_A;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_rd = (action == ACT_LOAD) && sts.in_ok && !sts.full;
          cmd.drop    = (action == ACT_LOAD) && sts.in_ok && sts.full;
          cmd.clear   = (action == ACT_CLEAR);
        end
      end
      S_LOAD:   cmd.load_wr = 1'b1;
      S_INIT:   cmd.run_init = 1'b1;
      S_ROOT: begin
        if (!sts.r_done) begin
          cmd.root_next  = sts.r_seen;
          cmd.root_start = !sts.r_seen;
        end
      end
      S_DISC_A: cmd.head_rd = 1'b1;
      S_DISC_B: cmd.disc_do = 1'b1;
      S_EDGE_A: cmd.edge_rd = !sts.e_end;
      S_EDGE_B: cmd.edge_chk = 1'b1;
      S_EDGE_C: cmd.disc_cmp = 1'b1;
      S_POP_A:  cmd.pop_a = 1'b1;
      S_POP_B:  cmd.pop_b = 1'b1;
      S_OUT_A:  cmd.out_rd = 1'b1;
      S_OUT_B:  cmd.out_load = 1'b1;
      S_OUT_C:  cmd.out_adv = m_tready;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/apf_datapath.sv =====
`timescale 1ns / 1ps
module apf_datapath import apf_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_ENTRIES  = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic [VTX_W-1:0] in_vertex,
  input  logic [VTX_W-1:0] in_neighbor,
  input  cmd_t             cmd,
  output status_t          sts,
  output logic             m_tvalid,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = AW + 1;
  localparam logic [EW-1:0] END_MARK = EW'(MAX_ENTRIES);
  localparam int ENT_W = EW + VW;
  localparam int STK_W = VW + EW + DISC_W + DISC_W + 1;

  typedef struct packed {
    logic [VW-1:0]     v;
    logic [EW-1:0]     e;
    logic [DISC_W-1:0] low;
    logic [DISC_W-1:0] disc;
    logic              cut;
  } stk_t;

  // Configuration and counters
  logic [CFG_W-1:0]  vcount;
  logic [CW-1:0]     n;
  logic [EW-1:0]     ec;
  logic              dropped;
  logic [MAX_VERTICES-1:0] head_vld;
  logic [MAX_VERTICES-1:0] seen;
  logic              head_vq;
  logic [VW-1:0]     ld_v;
  logic [VW-1:0]     ld_nb;
  logic [CW-1:0]     r;
  logic [VW-1:0]     tgt;
  logic [CW-1:0]     sp;
  logic [DISC_W-1:0] nd;
  logic [DISC_W-1:0] rc;
  logic [VW-1:0]     oi;
  stk_t              top;

  // Memory ports
  logic [VW-1:0]     head_raddr;
  logic [EW-1:0]     head_rdata;
  logic [ENT_W-1:0]  ent_rdata;
  logic [EW-1:0]     ent_nx;
  logic [VW-1:0]     ent_t;
  logic [DISC_W-1:0] disc_rdata;
  logic [STK_W-1:0]  stk_rdata;
  stk_t              par;
  logic              cut_wdata;
  logic              cut_rdata;
  logic [EW-1:0]     head_e;
  logic              cut_hit;
  logic [CW-1:0]     sp_m1;
  logic [CW-1:0]     sp_m2;

  always_comb begin
    if (vcount == '0) begin
      n = CW'(1);
    end else if (int'(vcount) > MAX_VERTICES) begin
      n = CW'(MAX_VERTICES);
    end else begin
      n = CW'(vcount);
    end
  end

  assign ent_nx     = ent_rdata[ENT_W-1:VW];
  assign ent_t      = ent_rdata[VW-1:0];
  assign par        = stk_t'(stk_rdata);
  assign head_raddr = cmd.load_rd ? VW'(in_vertex) : tgt;
  assign head_e     = head_vq ? head_rdata : END_MARK;
  assign sp_m1      = sp - CW'(1);
  assign sp_m2      = sp - CW'(2);
  assign cut_wdata  = (sp == CW'(1)) ? (rc >= DISC_W'(2)) : top.cut;
  assign cut_hit    = (sp > CW'(2)) && (top.low >= par.disc);

  // Status toward the controller
  always_comb begin
    sts.in_ok    = (int'(in_vertex) < int'(n)) && (int'(in_neighbor) < int'(n));
    sts.full     = (ec >= END_MARK);
    sts.r_done   = (r >= n);
    sts.r_seen   = seen[r[VW-1:0]];
    sts.e_end    = (top.e == END_MARK);
    sts.t_oob    = (int'(ent_t) >= int'(n));
    sts.t_seen   = seen[ent_t];
    sts.sp_one   = (sp == CW'(1));
    sts.can_push = (int'(sp) < MAX_VERTICES);
    sts.out_last = (int'(oi) + 1 == int'(n));
  end

  apf_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head (
    .clk(clk), .we(cmd.load_wr), .waddr(ld_v), .wdata(ec),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  apf_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_entry (
    .clk(clk), .we(cmd.load_wr), .waddr(ec[AW-1:0]), .wdata({head_e, ld_nb}),
    .raddr(top.e[AW-1:0]), .rdata(ent_rdata)
  );

  apf_ram #(.WIDTH(DISC_W), .DEPTH(MAX_VERTICES)) u_disc (
    .clk(clk), .we(cmd.disc_do), .waddr(tgt), .wdata(nd),
    .raddr(ent_t), .rdata(disc_rdata)
  );

  apf_ram #(.WIDTH(STK_W), .DEPTH(MAX_VERTICES)) u_stack (
    .clk(clk), .we(cmd.disc_do && (sp != '0)), .waddr(sp_m1[VW-1:0]),
    .wdata(top), .raddr(sp_m2[VW-1:0]), .rdata(stk_rdata)
  );

  apf_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_cut (
    .clk(clk), .we(cmd.pop_a), .waddr(top.v), .wdata(cut_wdata),
    .raddr(oi), .rdata(cut_rdata)
  );

  // Control state: configuration, list validity, counters, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount   <= CFG_RESET;
      ec       <= '0;
      dropped  <= 1'b0;
      head_vld <= '0;
      seen     <= '0;
      r        <= '0;
      sp       <= '0;
      nd       <= '0;
      rc       <= '0;
      oi       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        vcount <= cfg_wdata;
      end
      if (cmd.clear) begin
        ec       <= '0;
        dropped  <= 1'b0;
        head_vld <= '0;
      end
      if (cmd.drop) begin
        dropped <= 1'b1;
      end
      if (cmd.load_wr) begin
        ec             <= ec + EW'(1);
        head_vld[ld_v] <= 1'b1;
      end
      if (cmd.run_init) begin
        seen <= '0;
        r    <= '0;
        nd   <= '0;
        oi   <= '0;
      end
      if (cmd.root_next) begin
        r <= r + CW'(1);
      end
      if (cmd.root_start) begin
        sp <= '0;
        rc <= '0;
      end
      if (cmd.disc_do) begin
        seen[tgt] <= 1'b1;
        nd        <= nd + DISC_W'(1);
        sp        <= sp + CW'(1);
      end
      if (cmd.edge_chk && !sts.t_oob && !sts.t_seen && sts.sp_one) begin
        rc <= rc + DISC_W'(1);
      end
      if (cmd.pop_a && sts.sp_one) begin
        sp <= '0;
      end
      if (cmd.pop_b) begin
        sp <= sp_m1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end
      if (cmd.out_adv) begin
        m_tvalid <= 1'b0;
        oi       <= oi + VW'(1);
      end
    end
  end

  // Payload: load capture, search top of stack, output word
  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      ld_v    <= VW'(in_vertex);
      ld_nb   <= VW'(in_neighbor);
    end
    if (cmd.load_rd || cmd.head_rd) begin
      head_vq <= head_vld[head_raddr];
    end
    if (cmd.root_start) begin
      tgt <= r[VW-1:0];
    end
    if (cmd.disc_do) begin
      top.v    <= tgt;
      top.e    <= head_e;
      top.low  <= nd;
      top.disc <= nd;
      top.cut  <= 1'b0;
    end
    if (cmd.edge_chk) begin
      top.e <= ent_nx;
      tgt   <= ent_t;
    end
    if (cmd.disc_cmp && (disc_rdata < top.low)) begin
      top.low <= disc_rdata;
    end
    if (cmd.pop_b) begin
      top.v    <= par.v;
      top.e    <= par.e;
      top.low  <= (top.low < par.low) ? top.low : par.low;
      top.disc <= par.disc;
      top.cut  <= par.cut | cut_hit;
    end
    if (cmd.out_load) begin
      m_tdata <= {dropped, cut_rdata, VTX_W'(oi)};
      m_tlast <= sts.out_last;
    end
  end

  // Bounds of the stack pointer and the entry count, stack depth on push and pop, output valid after a load
  a_ec_bound: assert property (@(posedge clk) disable iff (rst)
    int'(ec) <= MAX_ENTRIES) else $error("entry count beyond capacity");
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    int'(sp) <= MAX_VERTICES) else $error("stack pointer beyond depth");
  a_pop_depth: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_b |-> sp >= CW'(2)) else $error("parent pop on shallow stack");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.disc_do |-> int'(sp) < MAX_VERTICES) else $error("push on full stack");
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid) else $error("result not presented");

endmodule

// ===== hw/rtl/articulation_point_finder_top.sv =====
`timescale 1ns / 1ps
// Articulation point finder: load directed adjacency words (action 0), clear
// the graph (action 2) or run a depth-first search (action 1) that returns one
// word per vertex in use, in ascending order, with tlast on the final one.
// Input words are taken one at a time: a stored load does a head-pointer
// read, then a list write; a clear, a dropped load or an unused action is
// taken in the idle state alone. A run walks each vertex in use through a
// root scan, head read, discovery, end-of-list check and pop, visits each
// adjacency entry (with a discovery compare when its target is already
// discovered), then reads, loads and presents one result word per vertex,
// which can stall on the output. The search sequencer steps through the head,
// entry, discovery and stack memories.
// No input word is taken during a run. There is no clearing pass after reset.
module articulation_point_finder_top import apf_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_ENTRIES  = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,   // vertex_count
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,     // vertex[5:0], neighbor[11:6], zero fill
  input  logic [1:0]       s_tuser,     // action[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,     // result_vertex[5:0], is_cut[6], overflow[7]
  output logic             m_tlast
);

  cmd_t    cmd;
  status_t sts;

  apf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .action(s_tuser),
    .m_tready(m_tready), .sts(sts), .s_tready(s_tready), .cmd(cmd)
  );

  apf_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_vertex(s_tdata[5:0]), .in_neighbor(s_tdata[11:6]), .cmd(cmd), .sts(sts),
    .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule
